// ----- src/bhs_pkg.sv -----
// Shared types and codes for the bounded history stack.
`timescale 1ns / 1ps
`default_nettype none

package bhs_pkg;

  // Operation codes carried in in_tuser
  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_BACK   = 2'd1;
  localparam logic [1:0] MODE_REBASE = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  localparam int IN_ID_W    = 8;
  localparam int OUT_ID_W   = 8;
  localparam int OUT_DEP_W  = 4;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_BACK,
    ST_DONE
  } bhs_state_t;

  // Per-cell load controls from the sequencer
  typedef struct packed {
    logic ld_id;   // take the broadcast identifier
    logic ld_nbr;  // take the entry of the next cell up
  } bhs_cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/bhs_cell.sv -----
// One stack entry of the cell row: loads a new identifier or its upper neighbor.
`timescale 1ns / 1ps
`default_nettype none

module bhs_cell
  import bhs_pkg::*;
#(
  parameter int ID_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bhs_cell_ctl_t      ctl,
  input  wire logic [ID_BITS-1:0] id_in,
  input  wire logic [ID_BITS-1:0] nbr_in,
  output logic      [ID_BITS-1:0] entry
);

  logic [ID_BITS-1:0] entry_r;
  logic [ID_BITS-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.ld_id) begin
      entry_nxt = id_in;
    end else if (ctl.ld_nbr) begin
      entry_nxt = nbr_in;
    end else begin
      entry_nxt = entry_r;
    end
  end

  // Clear on reset so the base entry starts at zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ----- src/bounded_history_stack.sv -----
// Top level: history stack built from a row of entry cells and a scan sequencer.
// Sequence: push of the top, rebase and back at base go from idle straight to ST_DONE;
// back steps through ST_RD, ST_BACK, ST_DONE; push and query scan the row in ST_RD, ST_CMP per entry.
// Throughput: one item at a time, accepted only in idle; the entry scan through the single row
// read port and any output stall in ST_DONE set the pace.
// Reset: synchronous active-low rst_n leaves one base entry of 0, depth 1, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module bounded_history_stack
  import bhs_pkg::*;
#(
  parameter int MAX_DEPTH = 8,
  parameter int ID_BITS   = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] surface_id
  input  wire logic [1:0]             in_tuser,   // [1:0] mode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] changed, [8:1] leaving_id, [16:9] entering_id, [17] held,
  // [21:18] stack_depth, [23:22] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  bhs_state_t state_r, state_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic [ID_BITS-1:0] top_r, top_nxt;
  logic [AW-1:0]      scan_r, scan_nxt;
  logic [ID_BITS-1:0] lv_r, lv_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               chg_r, chg_nxt;
  logic               held_r, held_nxt;
  logic [ID_BITS-1:0] rd_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic               out_ld;

  logic [ID_BITS-1:0] id_in;
  logic               wr_en;
  logic [AW-1:0]      wr_idx;
  logic [ID_BITS-1:0] wr_data;
  logic               shift_en;
  logic               scan_last;

  logic [ID_BITS-1:0] ent [MAX_DEPTH];
  bhs_cell_ctl_t      cell_ctl [MAX_DEPTH];

  assign id_in     = ID_BITS'(in_tdata[IN_ID_W-1:0]);
  assign in_tready = (state_r == ST_IDLE);
  assign scan_last = ((DW'(scan_r) + DW'(1)) == depth_r);

  // Cell row
  for (genvar gi = 0; gi < MAX_DEPTH; gi++) begin : g_cell
    logic [ID_BITS-1:0] nbr;
    if (gi + 1 < MAX_DEPTH) begin : g_nbr
      assign nbr = ent[gi+1];
    end else begin : g_top
      assign nbr = '0;
    end

    always_comb begin
      cell_ctl[gi].ld_id  = wr_en && (wr_idx == AW'(gi));
      cell_ctl[gi].ld_nbr = shift_en && (gi >= 1) && (gi + 2 <= MAX_DEPTH);
    end

    bhs_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl[gi]),
      .id_in (wr_data),
      .nbr_in(nbr),
      .entry (ent[gi])
    );
  end

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    top_nxt   = top_r;
    scan_nxt  = scan_r;
    lv_nxt    = lv_r;
    id_nxt    = id_r;
    mode_nxt  = mode_r;
    chg_nxt   = chg_r;
    held_nxt  = held_r;
    wr_en     = 1'b0;
    wr_idx    = '0;
    wr_data   = id_r;
    shift_en  = 1'b0;
    out_ld    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tuser;
          id_nxt   = id_in;
          lv_nxt   = top_r;
          chg_nxt  = 1'b0;
          held_nxt = 1'b0;
          scan_nxt = '0;
          unique case (in_tuser)
            MODE_PUSH: begin
              state_nxt = (id_in == top_r) ? ST_DONE : ST_RD;
            end
            MODE_BACK: begin
              if (depth_r > DW'(1)) begin
                scan_nxt  = AW'(depth_r - DW'(2));
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            MODE_REBASE: begin
              chg_nxt   = !((depth_r == DW'(1)) && (top_r == id_in));
              wr_en     = 1'b1;
              wr_idx    = '0;
              wr_data   = id_in;
              depth_nxt = DW'(1);
              top_nxt   = id_in;
              state_nxt = ST_DONE;
            end
            MODE_QUERY: begin
              state_nxt = ST_RD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = (mode_r == MODE_BACK) ? ST_BACK : ST_CMP;
      end
      ST_CMP: begin
        priority if (rd_data_r == id_r) begin
          if (mode_r == MODE_PUSH) begin
            // truncate back to the matching entry
            depth_nxt = DW'(scan_r) + DW'(1);
            top_nxt   = id_r;
            chg_nxt   = 1'b1;
          end else begin
            held_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (scan_last) begin
          if (mode_r == MODE_PUSH) begin
            wr_en = 1'b1;
            if (depth_r == DW'(MAX_DEPTH)) begin
              // drop the oldest entry above the base, append at the top
              shift_en = 1'b1;
              wr_idx   = AW'(MAX_DEPTH - 1);
            end else begin
              wr_idx    = AW'(depth_r);
              depth_nxt = depth_r + DW'(1);
            end
            top_nxt = id_r;
            chg_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          scan_nxt  = scan_r + AW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_BACK: begin
        top_nxt   = rd_data_r;
        depth_nxt = depth_r - DW'(1);
        chg_nxt   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_ld    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_ld || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= DW'(1);
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r    <= scan_nxt;
    lv_r      <= lv_nxt;
    id_r      <= id_nxt;
    mode_r    <= mode_nxt;
    chg_r     <= chg_nxt;
    held_r    <= held_nxt;
    rd_data_r <= ent[scan_r];
    if (out_ld) begin
      out_data_r <= {2'b00,
                     OUT_DEP_W'(depth_r),
                     held_r,
                     chg_r ? OUT_ID_W'(top_r) : {OUT_ID_W{1'b0}},
                     chg_r ? OUT_ID_W'(lv_r) : {OUT_ID_W{1'b0}},
                     chg_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r >= DW'(1)) && (depth_r <= DW'(MAX_DEPTH)))
    else $error("stack depth out of range");

  a_top_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (top_r == ent[AW'(depth_r - DW'(1))]))
    else $error("top register disagrees with cell row");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (DW'(scan_r) < depth_r))
    else $error("scan index beyond filled entries");

  a_unchanged_zero_ids: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[16:1] == 16'd0))
    else $error("identifiers reported without a change");

  a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_DONE))
    else $error("result issued outside the done step");

endmodule

`default_nettype wire
